// ===== src/i2cm_pkg.sv =====
// Shared types and constants of the I2C master bit engine.
`default_nettype none

package i2cm_pkg;

  // Byte geometry and counter widths
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned CntW      = $clog2(ByteBits + 1);
  localparam int unsigned HalfW     = 16;
  localparam int unsigned PollW     = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned QueueDepth = 2;

  // Register reset values
  localparam logic [HalfW-1:0] HalfReset = 16'd20;
  localparam logic [PollW-1:0] PollReset = 8'd250;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHalfPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPollLimit  = 2'd1;

  // Command codes
  typedef enum logic [2:0] {
    REQ_START    = 3'd0,
    REQ_STOP     = 3'd1,
    REQ_WRITE    = 3'd2,
    REQ_WAIT_ACK = 3'd3,
    REQ_READ     = 3'd4
  } req_e;

  // Bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_ST_HI = 4'd1,
    PH_ST_LO = 4'd2,
    PH_SP_LO = 4'd3,
    PH_SP_HI = 4'd4,
    PH_WR_HI = 4'd5,
    PH_WR_LO = 4'd6,
    PH_WA_RL = 4'd7,
    PH_WA_HI = 4'd8,
    PH_POLL  = 4'd9,
    PH_RD_LO = 4'd10,
    PH_RD_HI = 4'd11,
    PH_RA_LO = 4'd12,
    PH_RA_HI = 4'd13
  } phase_e;

  // Classified tick request held in the queue
  typedef struct packed {
    logic                cmd_ok;
    req_e                req;
    logic [ByteBits-1:0] tx_byte;
    logic                send_ack;
    logic                sda_sense;
  } item_t;

  // One result of a tick
  typedef struct packed {
    logic                scl_level;
    logic                sda_release;
    logic                busy_res;
    logic                done_res;
    logic [ByteBits-1:0] rx_byte;
    logic                ack_failed;
  } result_t;

endpackage

`default_nettype wire

// ===== src/i2cm_front.sv =====
// Front end: classify incoming tick requests and queue them for the sequencer.
`default_nettype none

module i2cm_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      cmd_valid_i,
  input  wire logic [2:0]                req_type_i,
  input  wire logic [7:0]                tx_byte_i,
  input  wire logic                      send_ack_i,
  input  wire logic                      sda_sense_i,
  input  wire logic                      pop_i,
  output logic                           item_valid_o,
  output i2cm_pkg::item_t                item_o
);

  localparam int unsigned PtrW = $clog2(i2cm_pkg::QueueDepth);
  localparam int unsigned CntQ = $clog2(i2cm_pkg::QueueDepth + 1);

  i2cm_pkg::item_t       slot_q [i2cm_pkg::QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CntQ-1:0]       count_q, count_d;
  i2cm_pkg::item_t       item_new;
  logic                  push;
  logic                  pop;

  // Classify: a command counts only when offered with a known code
  always_comb begin
    item_new.cmd_ok    = cmd_valid_i && (req_type_i <= i2cm_pkg::REQ_READ);
    item_new.req       = i2cm_pkg::req_e'(req_type_i);
    item_new.tx_byte   = tx_byte_i;
    item_new.send_ack  = send_ack_i;
    item_new.sda_sense = sda_sense_i;
  end

  // Queue handshake
  assign in_stall_o   = (count_q == CntQ'(i2cm_pkg::QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (count_q != '0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = slot_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(i2cm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(i2cm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the request
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

// ===== src/i2cm_back.sv =====
// Back end: bus sequencer, configuration registers and result register.
`default_nettype none

module i2cm_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire logic [i2cm_pkg::HalfW-1:0]          cfg_data_i,
  input  wire logic                                item_valid_i,
  input  wire i2cm_pkg::item_t                     item_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output i2cm_pkg::result_t                        res_o
);

  localparam int unsigned BB = i2cm_pkg::ByteBits;

  i2cm_pkg::phase_e                phase_q, phase_d;
  logic [i2cm_pkg::HalfW-1:0]      half_q;
  logic [i2cm_pkg::PollW-1:0]      limit_q;
  logic [i2cm_pkg::HalfW-1:0]      delay_q, delay_d;
  logic [i2cm_pkg::CntW-1:0]       bit_q, bit_d;
  logic [i2cm_pkg::CntW-1:0]       bit_inc;
  logic [i2cm_pkg::PollW-1:0]      poll_q, poll_d;
  logic [BB-1:0]                   shift_q, shift_d;
  logic [BB-1:0]                   rx_q, rx_d;
  logic                            ack_q, ack_d;
  logic                            scl_q, scl_d;
  logic                            sda_q, sda_d;
  logic                            choice_q, choice_d;
  logic                            done;
  logic [i2cm_pkg::HalfW-1:0]      delay_load;
  logic                            out_valid_q, out_valid_d;
  i2cm_pkg::result_t               res_q;

  // Take the next request once the result register is free or drains
  assign pop_o      = item_valid_i && (!out_valid_q || !out_stall_i);
  assign delay_load = (half_q == '0) ? i2cm_pkg::HalfW'(1) : half_q;
  assign bit_inc    = bit_q + 1'b1;

  // Next state of the sequencer for one tick
  always_comb begin
    phase_d  = phase_q;
    delay_d  = delay_q;
    bit_d    = bit_q;
    poll_d   = poll_q;
    shift_d  = shift_q;
    rx_d     = rx_q;
    ack_d    = ack_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    choice_d = choice_q;
    done     = 1'b0;
    if (pop_o) begin
      if (phase_q == i2cm_pkg::PH_IDLE) begin
        // Launch a command
        if (item_i.cmd_ok) begin
          bit_d = '0;
          case (item_i.req)
            i2cm_pkg::REQ_START: begin
              scl_d   = 1'b1;
              sda_d   = 1'b1;
              phase_d = i2cm_pkg::PH_ST_HI;
              delay_d = delay_load;
            end
            i2cm_pkg::REQ_STOP: begin
              scl_d   = 1'b0;
              sda_d   = 1'b0;
              phase_d = i2cm_pkg::PH_SP_LO;
              delay_d = delay_load;
            end
            i2cm_pkg::REQ_WRITE: begin
              sda_d   = item_i.tx_byte[BB-1];
              shift_d = {item_i.tx_byte[BB-2:0], 1'b0};
              scl_d   = 1'b1;
              phase_d = i2cm_pkg::PH_WR_HI;
              delay_d = delay_load;
            end
            i2cm_pkg::REQ_WAIT_ACK: begin
              ack_d   = 1'b0;
              poll_d  = '0;
              sda_d   = 1'b1;
              phase_d = i2cm_pkg::PH_WA_RL;
              delay_d = delay_load;
            end
            i2cm_pkg::REQ_READ: begin
              choice_d = item_i.send_ack;
              shift_d  = '0;
              scl_d    = 1'b0;
              sda_d    = 1'b1;
              phase_d  = i2cm_pkg::PH_RD_LO;
              delay_d  = delay_load;
            end
            default: begin
              phase_d = i2cm_pkg::PH_IDLE;
            end
          endcase
        end
      end else if (phase_q == i2cm_pkg::PH_POLL ||
                   (phase_q == i2cm_pkg::PH_WA_HI && delay_q <= i2cm_pkg::HalfW'(1))) begin
        // Poll SDA for the acknowledge
        phase_d = i2cm_pkg::PH_POLL;
        if (!item_i.sda_sense) begin
          scl_d   = 1'b0;
          ack_d   = 1'b0;
          phase_d = i2cm_pkg::PH_IDLE;
          done    = 1'b1;
        end else if (poll_q >= limit_q) begin
          ack_d   = 1'b1;
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = i2cm_pkg::PH_SP_LO;
          delay_d = delay_load;
        end else begin
          poll_d = poll_q + 1'b1;
        end
      end else if (delay_q > i2cm_pkg::HalfW'(1)) begin
        // Hold the bus levels
        delay_d = delay_q - 1'b1;
      end else begin
        // Step to the next phase
        case (phase_q)
          i2cm_pkg::PH_ST_HI: begin
            sda_d   = 1'b0;
            phase_d = i2cm_pkg::PH_ST_LO;
            delay_d = delay_load;
          end
          i2cm_pkg::PH_ST_LO: begin
            scl_d   = 1'b0;
            phase_d = i2cm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          i2cm_pkg::PH_SP_LO: begin
            scl_d   = 1'b1;
            sda_d   = 1'b1;
            phase_d = i2cm_pkg::PH_SP_HI;
            delay_d = delay_load;
          end
          i2cm_pkg::PH_SP_HI: begin
            phase_d = i2cm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          i2cm_pkg::PH_WR_HI: begin
            scl_d   = 1'b0;
            phase_d = i2cm_pkg::PH_WR_LO;
            delay_d = delay_load;
          end
          i2cm_pkg::PH_WR_LO: begin
            bit_d = bit_inc;
            if (bit_inc >= i2cm_pkg::CntW'(BB)) begin
              phase_d = i2cm_pkg::PH_IDLE;
              done    = 1'b1;
            end else begin
              sda_d   = shift_q[BB-1];
              shift_d = {shift_q[BB-2:0], 1'b0};
              scl_d   = 1'b1;
              phase_d = i2cm_pkg::PH_WR_HI;
              delay_d = delay_load;
            end
          end
          i2cm_pkg::PH_WA_RL: begin
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PH_WA_HI;
            delay_d = delay_load;
          end
          i2cm_pkg::PH_RD_LO: begin
            scl_d   = 1'b1;
            shift_d = {shift_q[BB-2:0], item_i.sda_sense};
            phase_d = i2cm_pkg::PH_RD_HI;
            delay_d = delay_load;
          end
          i2cm_pkg::PH_RD_HI: begin
            bit_d   = bit_inc;
            scl_d   = 1'b0;
            delay_d = delay_load;
            if (bit_inc >= i2cm_pkg::CntW'(BB)) begin
              sda_d   = !choice_q;
              phase_d = i2cm_pkg::PH_RA_LO;
            end else begin
              phase_d = i2cm_pkg::PH_RD_LO;
            end
          end
          i2cm_pkg::PH_RA_LO: begin
            scl_d   = 1'b1;
            phase_d = i2cm_pkg::PH_RA_HI;
            delay_d = delay_load;
          end
          i2cm_pkg::PH_RA_HI: begin
            scl_d   = 1'b0;
            rx_d    = shift_q;
            phase_d = i2cm_pkg::PH_IDLE;
            done    = 1'b1;
          end
          default: begin
            phase_d = i2cm_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  // Result register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cm_pkg::PH_IDLE;
      delay_q     <= '0;
      bit_q       <= '0;
      poll_q      <= '0;
      shift_q     <= '0;
      rx_q        <= '0;
      ack_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      choice_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      delay_q     <= delay_d;
      bit_q       <= bit_d;
      poll_q      <= poll_d;
      shift_q     <= shift_d;
      rx_q        <= rx_d;
      ack_q       <= ack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      choice_q    <= choice_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= i2cm_pkg::HalfReset;
      limit_q <= i2cm_pkg::PollReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == i2cm_pkg::CfgHalfPeriod) begin
        half_q <= cfg_data_i;
      end else if (cfg_index_i == i2cm_pkg::CfgPollLimit) begin
        limit_q <= cfg_data_i[i2cm_pkg::PollW-1:0];
      end
    end
  end

  // Capture the tick's result
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q.scl_level   <= scl_d;
      res_q.sda_release <= sda_d;
      res_q.busy_res    <= (phase_d != i2cm_pkg::PH_IDLE);
      res_q.done_res    <= done;
      res_q.rx_byte     <= rx_d;
      res_q.ack_failed  <= ack_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_engine_unit.sv =====
// Top level of the I2C master bit engine.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  in       | in_valid_i / in_stall_o   | cmd_valid, req_type, tx_byte, send_ack, sda
//  out      | out_valid_o / out_stall_i | scl, sda_release, busy, done, rx_byte, ack
//  cfg      | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One tick request is taken every clock cycle while in_stall_o is low; the sequencer
// finishes one tick per cycle unless the output stalls, so its state register loop sets
// the rate. A result passes through the queue, then the result register, to out_valid_o.
// The two-entry queue absorbs output stalls; in_stall_o rises only when it is full.
// Reset brings the bus to idle with SCL high and SDA released.
`default_nettype none

module i2c_master_bit_engine_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        cmd_valid_i,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [7:0]  tx_byte_i,
  input  wire logic        send_ack_i,
  input  wire logic        sda_sense_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             scl_level_o,
  output logic             sda_release_o,
  output logic             busy_res_o,
  output logic             done_res_o,
  output logic [7:0]       rx_byte_o,
  output logic             ack_failed_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t res;
  logic              item_valid;
  logic              pop;

  // Always ready for a register write
  assign cfg_ready_o = 1'b1;

  i2cm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_valid_i  (cmd_valid_i),
    .req_type_i   (req_type_i),
    .tx_byte_i    (tx_byte_i),
    .send_ack_i   (send_ack_i),
    .sda_sense_i  (sda_sense_i),
    .pop_i        (pop),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  i2cm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .res_o        (res)
  );

  // Unpack the result
  assign scl_level_o   = res.scl_level;
  assign sda_release_o = res.sda_release;
  assign busy_res_o    = res.busy_res;
  assign done_res_o    = res.done_res;
  assign rx_byte_o     = res.rx_byte;
  assign ack_failed_o  = res.ack_failed;

endmodule

`default_nettype wire

// ===== src/i2cm_checker.sv =====
// Port-level checks of the I2C master bit engine and their binding.
`default_nettype none

module i2cm_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       scl_level_o,
  input wire logic       sda_release_o,
  input wire logic       busy_res_o,
  input wire logic       done_res_o,
  input wire logic [7:0] rx_byte_o,
  input wire logic       ack_failed_o,
  input wire logic       cfg_ready_o
);

  // A completing tick leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !busy_res_o)
    else $error("done pulse while still busy");

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(scl_level_o) &&
      $stable(sda_release_o) && $stable(busy_res_o) && $stable(done_res_o) &&
      $stable(rx_byte_o) && $stable(ack_failed_o))
    else $error("stalled result changed");

  // A full queue frees a slot once a result drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && out_valid_o && !out_stall_i |=> !in_stall_o)
    else $error("queue stayed full after a result drained");

  // Register writes are never refused
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .scl_level_o   (scl_level_o),
  .sda_release_o (sda_release_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o),
  .rx_byte_o     (rx_byte_o),
  .ack_failed_o  (ack_failed_o),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

// ===== tb/sv/tb_i2c_master_bit_engine_unit.sv =====
// Self-checking testbench for the I2C master bit engine: random and directed bus ticks.
`timescale 1ns / 100ps

module tb_i2c_master_bit_engine_unit;

  localparam int unsigned HalfClk      = 5;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned WatchLimit   = 1000;
  localparam int unsigned RandTicks    = 1700;

  // Spare register slots that the engine must ignore
  localparam logic [i2cm_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [i2cm_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  // Command codes outside the defined set
  localparam logic [2:0] ReqFirstBad = 3'd5;
  localparam logic [2:0] ReqLastBad  = 3'd7;

  // How SDA is driven during the ticks of a command
  localparam int unsigned SdaLow    = 0;
  localparam int unsigned SdaHigh   = 1;
  localparam int unsigned SdaRandom = 2;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] req;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda;
  } tick_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        cmd_valid_i   = 1'b0;
  logic [2:0]  req_type_i    = '0;
  logic [7:0]  tx_byte_i     = '0;
  logic        send_ack_i    = 1'b0;
  logic        sda_sense_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        scl_level_o;
  logic        sda_release_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [7:0]  rx_byte_o;
  logic        ack_failed_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  // Pending bus ticks and the line states they should produce
  tick_t             tick_q[$];
  i2cm_pkg::result_t line_state_q[$];

  int unsigned err_count   = 0;
  int unsigned ticks_made  = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left    = 0;
  int unsigned stall_left  = 0;
  bit          pauses_on   = 1'b1;

  // Shadow of the engine registers and state
  logic [i2cm_pkg::HalfW-1:0]    half_ticks  = i2cm_pkg::HalfReset;
  logic [i2cm_pkg::PollW-1:0]    poll_lim    = i2cm_pkg::PollReset;
  i2cm_pkg::phase_e              bus_phase   = i2cm_pkg::PH_IDLE;
  logic [i2cm_pkg::HalfW-1:0]    bus_delay   = '0;
  logic [3:0]                    bit_idx     = '0;
  logic [i2cm_pkg::PollW-1:0]    poll_idx    = '0;
  logic [i2cm_pkg::ByteBits-1:0] shift_byte  = '0;
  logic                          ack_timeout = 1'b0;
  logic                          scl_q       = 1'b1;
  logic                          sda_q       = 1'b1;
  logic                          ack_sel     = 1'b0;
  logic [i2cm_pkg::ByteBits-1:0] rx_last     = '0;

  i2c_master_bit_engine_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_valid_i   (cmd_valid_i),
    .req_type_i    (req_type_i),
    .tx_byte_i     (tx_byte_i),
    .send_ack_i    (send_ack_i),
    .sda_sense_i   (sda_sense_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_level_o   (scl_level_o),
    .sda_release_o (sda_release_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_failed_o  (ack_failed_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(HalfClk) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bus engine shadow
  // ---------------------------------------------------------------------------

  // Enter a phase and load its delay; a zero half period still lasts one tick
  task automatic arm_delay(input i2cm_pkg::phase_e nxt);
    bus_phase = nxt;
    bus_delay = (half_ticks == '0) ? i2cm_pkg::HalfW'(1) : half_ticks;
  endtask

  // Put the next data bit on SDA with SCL high
  task automatic send_next_bit();
    sda_q      = shift_byte[i2cm_pkg::ByteBits-1];
    shift_byte = {shift_byte[i2cm_pkg::ByteBits-2:0], 1'b0};
    scl_q      = 1'b1;
    arm_delay(i2cm_pkg::PH_WR_HI);
  endtask

  // One ack poll: low ends the command, too many highs issue a stop
  task automatic poll_ack(input logic sda, inout logic done);
    if (!sda) begin
      scl_q       = 1'b0;
      ack_timeout = 1'b0;
      bus_phase   = i2cm_pkg::PH_IDLE;
      done        = 1'b1;
    end else if (poll_idx >= poll_lim) begin
      ack_timeout = 1'b1;
      scl_q       = 1'b0;
      sda_q       = 1'b0;
      arm_delay(i2cm_pkg::PH_SP_LO);
    end else begin
      poll_idx = poll_idx + 1'b1;
    end
  endtask

  // Advance the shadow by one tick and record the line state it leaves
  task automatic advance_bus_tick(input tick_t t);
    logic              done;
    i2cm_pkg::result_t lv;
    done = 1'b0;
    if (bus_phase == i2cm_pkg::PH_IDLE) begin
      if (t.cmd_valid && t.req <= i2cm_pkg::REQ_READ) begin
        bit_idx = '0;
        case (t.req)
          i2cm_pkg::REQ_START: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            arm_delay(i2cm_pkg::PH_ST_HI);
          end
          i2cm_pkg::REQ_STOP: begin
            scl_q = 1'b0;
            sda_q = 1'b0;
            arm_delay(i2cm_pkg::PH_SP_LO);
          end
          i2cm_pkg::REQ_WRITE: begin
            shift_byte = t.tx_byte;
            send_next_bit();
          end
          i2cm_pkg::REQ_WAIT_ACK: begin
            ack_timeout = 1'b0;
            poll_idx    = '0;
            sda_q       = 1'b1;
            arm_delay(i2cm_pkg::PH_WA_RL);
          end
          default: begin
            ack_sel    = t.send_ack;
            shift_byte = '0;
            scl_q      = 1'b0;
            sda_q      = 1'b1;
            arm_delay(i2cm_pkg::PH_RD_LO);
          end
        endcase
      end
    end else if (bus_phase == i2cm_pkg::PH_POLL) begin
      poll_ack(t.sda, done);
    end else if (bus_delay > 1) begin
      bus_delay = bus_delay - 1'b1;
    end else begin
      case (bus_phase)
        i2cm_pkg::PH_ST_HI: begin
          sda_q = 1'b0;
          arm_delay(i2cm_pkg::PH_ST_LO);
        end
        i2cm_pkg::PH_ST_LO: begin
          scl_q     = 1'b0;
          bus_phase = i2cm_pkg::PH_IDLE;
          done      = 1'b1;
        end
        i2cm_pkg::PH_SP_LO: begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          arm_delay(i2cm_pkg::PH_SP_HI);
        end
        i2cm_pkg::PH_SP_HI: begin
          bus_phase = i2cm_pkg::PH_IDLE;
          done      = 1'b1;
        end
        i2cm_pkg::PH_WR_HI: begin
          scl_q = 1'b0;
          arm_delay(i2cm_pkg::PH_WR_LO);
        end
        i2cm_pkg::PH_WR_LO: begin
          bit_idx = bit_idx + 1'b1;
          if (bit_idx >= i2cm_pkg::ByteBits) begin
            bus_phase = i2cm_pkg::PH_IDLE;
            done      = 1'b1;
          end else begin
            send_next_bit();
          end
        end
        i2cm_pkg::PH_WA_RL: begin
          scl_q = 1'b1;
          arm_delay(i2cm_pkg::PH_WA_HI);
        end
        i2cm_pkg::PH_WA_HI: begin
          bus_phase = i2cm_pkg::PH_POLL;
          poll_ack(t.sda, done);
        end
        i2cm_pkg::PH_RD_LO: begin
          scl_q      = 1'b1;
          shift_byte = {shift_byte[i2cm_pkg::ByteBits-2:0], t.sda};
          arm_delay(i2cm_pkg::PH_RD_HI);
        end
        i2cm_pkg::PH_RD_HI: begin
          bit_idx = bit_idx + 1'b1;
          scl_q   = 1'b0;
          if (bit_idx >= i2cm_pkg::ByteBits) begin
            sda_q = ~ack_sel;
            arm_delay(i2cm_pkg::PH_RA_LO);
          end else begin
            arm_delay(i2cm_pkg::PH_RD_LO);
          end
        end
        i2cm_pkg::PH_RA_LO: begin
          scl_q = 1'b1;
          arm_delay(i2cm_pkg::PH_RA_HI);
        end
        i2cm_pkg::PH_RA_HI: begin
          scl_q     = 1'b0;
          rx_last   = shift_byte;
          bus_phase = i2cm_pkg::PH_IDLE;
          done      = 1'b1;
        end
        default: bus_phase = i2cm_pkg::PH_IDLE;
      endcase
    end
    lv.scl_level   = scl_q;
    lv.sda_release = sda_q;
    lv.busy_res    = (bus_phase != i2cm_pkg::PH_IDLE);
    lv.done_res    = done;
    lv.rx_byte     = rx_last;
    lv.ack_failed  = ack_timeout;
    line_state_q.push_back(lv);
  endtask

  // ---------------------------------------------------------------------------
  // Pauses
  // ---------------------------------------------------------------------------

  // Mostly short bursts, now and then a long one
  function automatic int unsigned pick_burst();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cmd_valid_i <= 1'b0;
      req_type_i  <= '0;
      tx_byte_i   <= '0;
      send_ack_i  <= 1'b0;
      sda_sense_i <= 1'b0;
      gap_left    = 0;
    end else begin
      // Retire the accepted request into the shadow
      if (in_valid_i && !in_stall_o) begin
        advance_bus_tick(tick_q.pop_front());
        if (pauses_on && $urandom_range(0, 99) < 30) gap_left = pick_burst();
      end
      // Hold a stalled request, otherwise offer the next one or idle
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() != 0) begin
          in_valid_i  <= 1'b1;
          cmd_valid_i <= tick_q[0].cmd_valid;
          req_type_i  <= tick_q[0].req;
          tx_byte_i   <= tick_q[0].tx_byte;
          send_ack_i  <= tick_q[0].send_ack;
          sda_sense_i <= tick_q[0].sda;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    i2cm_pkg::result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  = 0;
    end else begin
      // Compare each accepted result with the oldest prediction
      if (out_valid_o && !out_stall_i) begin
        if (line_state_q.size() == 0) begin
          err_count++;
          $display({"%0t: unexpected result, expected none, actual scl %b sda %b",
                    " busy %b done %b rx %0h ack_failed %b"},
                   $time, scl_level_o, sda_release_o, busy_res_o, done_res_o, rx_byte_o,
                   ack_failed_o);
        end else begin
          want = line_state_q.pop_front();
          check_field("scl_level", want.scl_level, scl_level_o);
          check_field("sda_release", want.sda_release, sda_release_o);
          check_field("busy_res", want.busy_res, busy_res_o);
          check_field("done_res", want.done_res, done_res_o);
          check_field("rx_byte", want.rx_byte, rx_byte_o);
          check_field("ack_failed", want.ack_failed, ack_failed_o);
        end
      end
      // Stall the output in random bursts
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (pauses_on && $urandom_range(0, 99) < 25) begin
        stall_left  = pick_burst() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchLimit) begin
        $display("%0t: no progress for %0d cycles", $time, WatchLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Write one register and mirror it into the shadow
  task automatic write_reg(input logic [i2cm_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      i2cm_pkg::CfgHalfPeriod: half_ticks = val;
      i2cm_pkg::CfgPollLimit:  poll_lim   = val[i2cm_pkg::PollW-1:0];
      default: ;
    endcase
  endtask

  // Wait for every request and result to pass, then let the pipeline empty
  task automatic drain_and_wait();
    while (tick_q.size() != 0 || line_state_q.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic queue_tick(input logic vld, input logic [2:0] req, input logic [7:0] txb,
                            input logic ack, input logic sda);
    tick_t t;
    t.cmd_valid = vld;
    t.req       = req;
    t.tx_byte   = txb;
    t.send_ack  = ack;
    t.sda       = sda;
    tick_q.push_back(t);
    ticks_made++;
  endtask

  // Offer a command, then fill exactly its duration with busy ticks; the ticks
  // may carry commands that a busy engine must drop
  task automatic issue_cmd(input logic [2:0] req, input logic [7:0] txb, input logic ack,
                           input int unsigned high_polls, input int unsigned sda_mode);
    int unsigned h;
    int unsigned span;
    int unsigned i;
    int unsigned j;
    logic        sda;
    h = (half_ticks == '0) ? 1 : half_ticks;
    case (req)
      i2cm_pkg::REQ_START, i2cm_pkg::REQ_STOP: span = 2 * h;
      i2cm_pkg::REQ_WRITE:                     span = 16 * h;
      i2cm_pkg::REQ_READ:                      span = 18 * h;
      default: span = (high_polls <= poll_lim) ? 2 * h + high_polls : 4 * h + poll_lim;
    endcase
    queue_tick(1'b1, req, txb, ack, 1'($urandom));
    for (i = 1; i <= span; i++) begin
      if (sda_mode == SdaLow) sda = 1'b0;
      else if (sda_mode == SdaHigh) sda = 1'b1;
      else sda = 1'($urandom);
      // Polls start once SCL has been high for one delay
      if (req == i2cm_pkg::REQ_WAIT_ACK && i >= 2 * h) begin
        j = i - 2 * h;
        if (j < high_polls) sda = 1'b1;
        else if (j == high_polls) sda = 1'b0;
      end
      queue_tick($urandom_range(0, 3) == 0, 3'($urandom), 8'($urandom), 1'($urandom), sda);
    end
  endtask

  // A few idle ticks, some offering an undefined command
  task automatic idle_ticks();
    repeat ($urandom_range(0, 2)) begin
      queue_tick(1'($urandom), 3'($urandom_range(ReqFirstBad, ReqLastBad)), 8'($urandom),
                 1'($urandom), 1'($urandom));
    end
  endtask

  // Mostly an ack, sometimes on the last allowed poll, sometimes a timeout
  function automatic int unsigned pick_polls();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, (poll_lim < 4) ? poll_lim : 4);
    if (r < 8) return poll_lim;
    return poll_lim + 1 + $urandom_range(0, 3);
  endfunction

  // Start, address, ack, a few data bytes either way, stop
  task automatic bus_transaction();
    issue_cmd(i2cm_pkg::REQ_START, 8'($urandom), 1'($urandom), 0, SdaRandom);
    idle_ticks();
    issue_cmd(i2cm_pkg::REQ_WRITE, 8'($urandom), 1'($urandom), 0, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'($urandom), 1'($urandom), pick_polls(), SdaRandom);
    repeat ($urandom_range(1, 3)) begin
      idle_ticks();
      if ($urandom_range(0, 1) == 0) begin
        issue_cmd(i2cm_pkg::REQ_WRITE, 8'($urandom), 1'($urandom), 0, SdaRandom);
        issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'($urandom), 1'($urandom), pick_polls(),
                  SdaRandom);
      end else begin
        issue_cmd(i2cm_pkg::REQ_READ, 8'($urandom), 1'($urandom), 0, SdaRandom);
      end
    end
    issue_cmd(i2cm_pkg::REQ_STOP, 8'($urandom), 1'($urandom), 0, SdaRandom);
    idle_ticks();
  endtask

  initial begin : stimulus
    int unsigned r;
    logic [i2cm_pkg::HalfW-1:0] hp;
    logic [i2cm_pkg::PollW-1:0] lim;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of the registers: start and stop at the default half period
    issue_cmd(i2cm_pkg::REQ_START, 8'h00, 1'b0, 0, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_STOP, 8'hFF, 1'b1, 0, SdaRandom);
    drain_and_wait();

    // Zero half period, zero poll limit, spare slots ignored
    write_reg(i2cm_pkg::CfgHalfPeriod, 16'd0);
    write_reg(i2cm_pkg::CfgPollLimit, 16'd0);
    write_reg(CfgSpareA, 16'($urandom));
    write_reg(CfgSpareB, 16'($urandom));
    issue_cmd(i2cm_pkg::REQ_START, 8'h00, 1'b0, 0, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_WRITE, 8'h00, 1'b0, 0, SdaLow);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'h00, 1'b0, 0, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_WRITE, 8'hFF, 1'b1, 0, SdaHigh);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'hFF, 1'b1, 1, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_READ, 8'h00, 1'b1, 0, SdaHigh);
    issue_cmd(i2cm_pkg::REQ_READ, 8'hFF, 1'b0, 0, SdaLow);
    for (r = ReqFirstBad; r <= ReqLastBad; r++) begin
      queue_tick(1'b1, 3'(r), 8'($urandom), 1'($urandom), 1'($urandom));
    end
    issue_cmd(i2cm_pkg::REQ_WRITE, 8'hA5, 1'b0, 0, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_STOP, 8'h00, 1'b0, 0, SdaRandom);
    drain_and_wait();

    // Largest poll limit, upper data byte set to check that it is dropped
    write_reg(i2cm_pkg::CfgHalfPeriod, 16'd1);
    write_reg(i2cm_pkg::CfgPollLimit, 16'hFFFF);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'h00, 1'b0, 255, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'h00, 1'b0, 256, SdaRandom);
    drain_and_wait();

    // Ack on the last allowed poll, then one poll too many
    write_reg(i2cm_pkg::CfgHalfPeriod, 16'd2);
    write_reg(i2cm_pkg::CfgPollLimit, 16'd3);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'h00, 1'b0, 3, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_WAIT_ACK, 8'h00, 1'b0, 4, SdaRandom);
    issue_cmd(i2cm_pkg::REQ_READ, 8'h00, 1'b1, 0, SdaRandom);

    // Random phases: mostly short delays, a spread of poll limits
    while (ticks_made < RandTicks) begin
      drain_and_wait();
      r = $urandom_range(0, 9);
      if (r < 3) hp = 16'd1;
      else if (r < 6) hp = i2cm_pkg::HalfW'($urandom_range(2, 3));
      else if (r < 8) hp = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd4;
      else hp = i2cm_pkg::HalfW'($urandom_range(5, 8));
      r = $urandom_range(0, 9);
      if (r < 2) lim = 8'd1;
      else if (r < 3) lim = 8'd255;
      else if (r < 4) lim = 8'd0;
      else lim = i2cm_pkg::PollW'($urandom_range(2, 20));
      write_reg(i2cm_pkg::CfgHalfPeriod, hp);
      write_reg(i2cm_pkg::CfgPollLimit, {8'($urandom), lim});
      if ($urandom_range(0, 4) == 0) write_reg(CfgSpareB, 16'($urandom));
      pauses_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 5)) begin
        if (ticks_made < RandTicks) begin
          if ($urandom_range(0, 4) == 0) begin
            issue_cmd(3'($urandom_range(i2cm_pkg::REQ_START, i2cm_pkg::REQ_READ)),
                      8'($urandom), 1'($urandom), pick_polls(),
                      $urandom_range(SdaLow, SdaRandom));
            idle_ticks();
          end else begin
            bus_transaction();
          end
        end
      end
    end
    drain_and_wait();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
